// ===== hw/rtl/shs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        final_word;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} dig_item_t;

	// Element [0] is H0.
	typedef logic [7:0][31:0] hash_vec_t;

	typedef struct packed {
		logic take;
		logic append;
		logic pad;
		logic pad2;
		logic load;
		logic round;
		logic update;
		logic finish;
	} shs_cmd_t;

	typedef struct packed {
		logic block_full;
		logic final_item;
		logic pad_fits;
		logic round_last;
	} shs_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shs_datapath
	import shs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire msg_item_t   msg,
	input  wire shs_cmd_t    cmd,
	output shs_status_t      status,
	output hash_vec_t        hash
);

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Listed from H7 down to H0.
	localparam hash_vec_t InitHash = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenBytePos = 6'd56;

	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	logic [31:0]       word_q;
	logic [2:0]        cnt_q;
	logic              last_q;
	logic [5:0]        pos_q;
	logic [63:0]       bits_q;
	logic [5:0]        round_q;
	logic [15:0][31:0] blk_q;
	logic [15:0][31:0] win_q;
	logic [7:0][31:0]  vars_q;
	logic [31:0]       hkw_q;
	hash_vec_t         hash_q;

	logic [6:0]        room;
	logic [2:0]        take_n;
	logic [6:0]        lane_pos [4];
	logic              lane_en  [4];
	logic [31:0]       t1;
	logic [31:0]       t2;
	logic [31:0]       w_next;
	logic [2:0]        cnt_clamp;

	always_comb begin
		room = 7'd64 - {1'b0, pos_q};
		take_n = ({4'b0, cnt_q} > room) ? room[2:0] : cnt_q;
		for (int i = 0; i < 4; i++) begin
			lane_pos[i] = {1'b0, pos_q} + 7'(i);
			lane_en[i] = (3'(i) < cnt_q) && !lane_pos[i][6];
		end
		cnt_clamp = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;
		t1 = hkw_q + big_s1(vars_q[4])
			+ ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]));
		t2 = big_s0(vars_q[0])
			+ ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
		w_next = small_s1(win_q[14]) + win_q[9] + small_s0(win_q[1]) + win_q[0];
	end

	assign status.block_full = ({1'b0, pos_q} + {4'b0, cnt_q}) >= 7'd64;
	assign status.final_item = last_q;
	assign status.pad_fits = pos_q < LenBytePos;
	assign status.round_last = round_q == 6'd63;
	assign hash = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			hash_q <= InitHash;
		end else begin
			if (cmd.append) begin
				pos_q <= pos_q + {3'b000, take_n};
				bits_q <= bits_q + {58'b0, take_n, 3'b000};
			end
			if (cmd.pad) begin
				pos_q <= '0;
			end
			if (cmd.load) begin
				round_q <= '0;
			end
			if (cmd.round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.update) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + vars_q[i];
				end
			end
			if (cmd.finish) begin
				hash_q <= InitHash;
				bits_q <= '0;
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			word_q <= msg.message_word;
			cnt_q <= cnt_clamp;
			last_q <= msg.final_word;
		end
		if (cmd.append) begin
			// Bytes past the end of the block stay in word_q for the next pass.
			for (int i = 0; i < 4; i++) begin
				if (lane_en[i]) begin
					blk_q[lane_pos[i][5:2]][{~lane_pos[i][1:0], 3'b000} +: 8]
						<= word_q[8*(3-i) +: 8];
				end
			end
			word_q <= word_q << {take_n, 3'b000};
			cnt_q <= cnt_q - take_n;
		end
		if (cmd.pad) begin
			for (int w = 0; w < 16; w++) begin
				for (int b = 0; b < 4; b++) begin
					if (6'(4*w + b) == pos_q) begin
						blk_q[w][8*(3-b) +: 8] <= PadByte;
					end else if (6'(4*w + b) > pos_q && (w < 14 || pos_q >= LenBytePos)) begin
						blk_q[w][8*(3-b) +: 8] <= 8'h00;
					end
				end
			end
			if (pos_q < LenBytePos) begin
				blk_q[14] <= bits_q[63:32];
				blk_q[15] <= bits_q[31:0];
			end
		end
		if (cmd.pad2) begin
			for (int w = 0; w < 14; w++) begin
				blk_q[w] <= '0;
			end
			blk_q[14] <= bits_q[63:32];
			blk_q[15] <= bits_q[31:0];
		end
		if (cmd.load) begin
			win_q <= blk_q;
			vars_q <= hash_q;
			hkw_q <= hash_q[7] + RoundK[0] + blk_q[0];
		end
		if (cmd.round) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
			// Next round's h is today's g, so h + K + W for the next round is prepared in this round.
			hkw_q <= vars_q[6] + RoundK[round_q + 6'd1] + win_q[1];
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_next;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/shs_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shs_out
	import shs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire hash_vec_t digest,
	output logic           dig_valid,
	input  wire logic      dig_stall,
	output dig_item_t      dig,
	output logic           empty
);

	logic [7:0][31:0] buf_q;
	logic [3:0]       left_q;
	logic [2:0]       idx_q;
	logic             pop;

	assign dig_valid = left_q != 4'd0;
	assign empty = left_q == 4'd0;
	assign pop = dig_valid && !dig_stall;
	assign dig.digest_word = buf_q[0];
	assign dig.digest_index = idx_q;
	assign dig.digest_last = idx_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			left_q <= 4'd8;
			idx_q <= '0;
		end else if (pop) begin
			left_q <= left_q - 4'd1;
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= digest;
		end else if (pop) begin
			for (int i = 0; i < 7; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/shs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shs_ctrl
	import shs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        msg_valid,
	output logic             msg_stall,
	input  wire shs_status_t status,
	input  wire logic        out_empty,
	output shs_cmd_t         cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b00000001,
		S_APPEND = 8'b00000010,
		S_PAD    = 8'b00000100,
		S_PAD2   = 8'b00001000,
		S_LOAD   = 8'b00010000,
		S_ROUND  = 8'b00100000,
		S_UPDATE = 8'b01000000,
		S_FINISH = 8'b10000000
	} ctrl_state_t;

	ctrl_state_t state_q, state_d;
	// Where to continue once the running compression has been folded into the hash.
	ctrl_state_t ret_q, ret_d;

	assign msg_stall = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			S_IDLE: begin
				if (msg_valid) begin
					cmd.take = 1'b1;
					state_d = S_APPEND;
				end
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				if (status.block_full) begin
					ret_d = S_APPEND;
					state_d = S_LOAD;
				end else if (status.final_item) begin
					state_d = S_PAD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PAD: begin
				cmd.pad = 1'b1;
				ret_d = status.pad_fits ? S_FINISH : S_PAD2;
				state_d = S_LOAD;
			end
			S_PAD2: begin
				cmd.pad2 = 1'b1;
				ret_d = S_FINISH;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (status.round_last) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ret_q;
			end
			S_FINISH: begin
				if (out_empty) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_stream_hash_core.sv =====
// SHA-256 over a byte stream delivered as big-endian 32-bit words.
// The msg channel carries one word per transaction with its count of leading
// valid bytes (counts above four act as four) and a final flag; a zero count
// with the final flag ends the message with no more bytes. The dig channel
// returns the eight digest words, H0 first, with their index and a last flag.
// One message word is taken per transaction; msg_stall is high from the cycle
// after acceptance until the word has been packed.
// Every completed 64-byte block adds a load step, 64 rounds (one per cycle on
// the single round unit), one hash update and a second packing pass for the
// rest of the word.
// After the final transaction the digest follows the compression of any block
// completed by the final word, then of the padded block and of a further block
// when the padding spills over. Digest words then leave one per cycle while
// dig_stall is low. A new message may start while the digest is still
// draining; its own digest waits until the previous one has gone.
// Reset clears the controller, the byte and bit counters, and loads the
// initial hash values; no digest is pending after reset. While the receiver
// stalls, the current digest word and its index hold steady.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hash_core
	import shs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	output logic           msg_stall,
	input  wire msg_item_t msg,
	output logic           dig_valid,
	input  wire logic      dig_stall,
	output dig_item_t      dig
);

	shs_cmd_t    cmd;
	shs_status_t status;
	hash_vec_t   hash;
	logic        out_empty;

	shs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.status    (status),
		.out_empty (out_empty),
		.cmd       (cmd)
	);

	shs_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.cmd    (cmd),
		.status (status),
		.hash   (hash)
	);

	shs_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (cmd.finish),
		.digest    (hash),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig),
		.empty     (out_empty)
	);

	// An accepted word is always followed by packing, with msg_stall raised.
	assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall |=> msg_stall)
		else $error("message word accepted without a packing cycle");

	// A digest always starts at index zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> dig.digest_index == 3'd0)
		else $error("digest started at a nonzero index");

	// The eighth word closes the digest; nothing follows it directly.
	assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && dig.digest_last |=> !dig_valid)
		else $error("digest continued past its last word");

	// The hash is never re-armed while an earlier digest is still draining.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !dig_valid)
		else $error("digest loaded over a pending one");

endmodule

`default_nettype wire

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker
	import shs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      msg_valid,
	input  wire logic      msg_stall,
	input  wire msg_item_t msg,
	input  wire logic      dig_valid,
	input  wire logic      dig_stall,
	input  wire dig_item_t dig,
	output int             mismatch_count,
	output int             words_due,
	output int             words_checked
);

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [0:7][31:0] INITIAL_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] chain_hash [8];
	logic [31:0] block_words [16];
	int unsigned block_fill;
	logic [63:0] message_bits;
	dig_item_t   digest_q [$];
	dig_item_t   oldest;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic rearm();
		int i;
		for (i = 0; i < 8; i++) begin
			chain_hash[i] = INITIAL_HASH[i];
		end
		block_fill = 0;
		message_bits = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] x15, x2, t1, t2;
		int r;
		for (r = 0; r < 16; r++) begin
			w[r] = block_words[r];
		end
		a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
		e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
		for (r = 0; r < 64; r++) begin
			// The schedule is kept in a rolling window of sixteen words.
			if (r >= 16) begin
				x15 = w[(r - 15) & 15];
				x2 = w[(r - 2) & 15];
				w[r & 15] = w[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
					+ w[(r - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
			end
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_K[r] + w[r & 15];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
		chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
	endtask

	task automatic append_byte(input logic [7:0] value);
		int unsigned slot;
		slot = block_fill >> 2;
		if ((block_fill & 3) == 0) begin
			block_words[slot] = '0;
		end
		block_words[slot] = block_words[slot] | ({24'b0, value} << (24 - 8 * (block_fill & 3)));
		block_fill++;
		if (block_fill == 64) begin
			compress_block();
			block_fill = 0;
		end
	endtask

	task automatic absorb_item(input msg_item_t item);
		int n, i;
		dig_item_t word_out;
		n = (item.valid_bytes > 3'd4) ? 4 : int'(item.valid_bytes);
		for (i = 0; i < n; i++) begin
			append_byte(8'(item.message_word >> (24 - 8 * i)));
			message_bits += 64'd8;
		end
		if (item.final_word) begin
			append_byte(8'h80);
			while (block_fill != 56) begin
				append_byte(8'h00);
			end
			block_words[14] = message_bits[63:32];
			block_words[15] = message_bits[31:0];
			compress_block();
			for (i = 0; i < 8; i++) begin
				word_out.digest_word = chain_hash[i];
				word_out.digest_index = 3'(i);
				word_out.digest_last = (i == 7);
				digest_q.push_back(word_out);
			end
			rearm();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm();
			digest_q.delete();
			mismatch_count = 0;
			words_checked <= 0;
			words_due <= 0;
		end else begin
			if (dig_valid && !dig_stall) begin
				words_checked <= words_checked + 1;
				if (digest_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: digest transaction with nothing expected: expected none, got %h/%0d/%b",
						$time, dig.digest_word, dig.digest_index, dig.digest_last);
				end else begin
					oldest = digest_q.pop_front();
					if (dig.digest_word !== oldest.digest_word) begin
						mismatch_count++;
						$display("%0t: digest_word mismatch: expected %h, got %h",
							$time, oldest.digest_word, dig.digest_word);
					end
					if (dig.digest_index !== oldest.digest_index) begin
						mismatch_count++;
						$display("%0t: digest_index mismatch: expected %0d, got %0d",
							$time, oldest.digest_index, dig.digest_index);
					end
					if (dig.digest_last !== oldest.digest_last) begin
						mismatch_count++;
						$display("%0t: digest_last mismatch: expected %b, got %b",
							$time, oldest.digest_last, dig.digest_last);
					end
				end
			end
			if (msg_valid && !msg_stall) begin
				absorb_item(msg);
			end
			words_due <= digest_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_sha256_stream_hash_core.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hash_core;
	import shs_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 450;
	localparam int HOLD_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 300;

	logic      clk;
	logic      arst_n;
	logic      msg_valid;
	logic      msg_stall;
	msg_item_t msg;
	logic      dig_valid;
	logic      dig_stall;
	dig_item_t dig;

	int mismatch_count;
	int words_due;
	int words_checked;
	int cycle_count;
	int items_sent;
	int messages_sent;
	bit calm;
	bit hold_req;
	bit hold_done;

	sha256_stream_hash_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	sha256_digest_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg_valid),
		.msg_stall      (msg_stall),
		.msg            (msg),
		.dig_valid      (dig_valid),
		.dig_stall      (dig_stall),
		.dig            (dig),
		.mismatch_count (mismatch_count),
		.words_due      (words_due),
		.words_checked  (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Cycle limit of %0d reached with %0d digest words outstanding.",
			CYCLE_LIMIT, words_due);
		$display("end of test: mismatches");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Receiver: random stall pattern, a quiet mode, and a long hold-off on request.
	initial begin
		dig_stall = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				dig_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm) begin
				dig_stall <= 1'b0;
				@(posedge clk);
			end else begin
				dig_stall <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
				dig_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	task automatic send_word(input logic [31:0] word, input logic [2:0] count,
		input logic last);
		msg_item_t item;
		int gap;
		item.message_word = word;
		item.valid_bytes = count;
		item.final_word = last;
		msg <= item;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_stall) begin
			@(posedge clk);
		end
		items_sent++;
		if (last) begin
			messages_sent++;
		end
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_message(input int words);
		logic [2:0] count;
		int k, roll;
		for (k = 0; k < words; k++) begin
			if (k == words - 1) begin
				count = 3'($urandom_range(0, 7));
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 84) begin
					count = 3'd4;
				end else if (roll < 92) begin
					count = 3'($urandom_range(1, 3));
				end else if (roll < 96) begin
					count = 3'd0;
				end else begin
					count = 3'($urandom_range(5, 7));
				end
			end
			send_word($urandom, count, k == words - 1);
		end
	endtask

	task automatic wait_all_digests();
		msg_valid <= 1'b0;
		@(negedge clk);
		wait (words_due == 0);
		@(posedge clk);
	endtask

	initial begin
		int k, n;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		items_sent = 0;
		messages_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, then a three-byte message whose unused byte is nonzero.
		send_word(32'h0000_0000, 3'd0, 1'b1);
		send_word(32'h6162_63ff, 3'd3, 1'b1);
		// Counts above four act as four.
		send_word(32'hffff_ffff, 3'd7, 1'b0);
		send_word(32'h0000_0000, 3'd5, 1'b1);
		// Short words and an empty word in the middle of a message.
		send_word(32'ha5c3_0f96, 3'd1, 1'b0);
		send_word(32'h5a3c_f069, 3'd2, 1'b0);
		send_word(32'hffff_ffff, 3'd0, 1'b0);
		send_word(32'h1234_5678, 3'd3, 1'b0);
		send_word(32'h8000_0001, 3'd4, 1'b1);
		// 56 bytes: the length no longer fits, so padding spills into a second block.
		for (k = 0; k < 14; k++) begin
			send_word((k % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000, 3'd4, k == 13);
		end

		k = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 7) == 0);
			if (k == 8) begin
				// The receiver holds off while messages keep coming, so the block backs up.
				calm = 1'b0;
				hold_req = 1'b1;
			end
			if (k == 20 || k == 33) begin
				wait_all_digests();
			end
			n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 17) : $urandom_range(18, 40);
			send_random_message(n);
			k++;
		end
		msg_valid <= 1'b0;
		calm = 1'b1;

		wait_all_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Hashed %0d messages from %0d message words; %0d digest words compared.",
			messages_sent, items_sent, words_checked);
		$display("Included empty, short, spilled-pad and oversized-count messages, a long hold-off and drains.");
		if (mismatch_count == 0 && words_due == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
